[sv/mck_pkg.sv]
package mck_pkg;

    localparam int CODE_W   = 8;
    localparam int CNT_W    = 4;
    localparam int ECNT_W   = 5;
    localparam int PAT_W    = 8;
    localparam int DOT_W    = 16;
    localparam int FACTOR_W = 3;
    localparam int RUN_W    = 18;
    localparam int PROD_W   = DOT_W + FACTOR_W;

    localparam logic [RUN_W-1:0] RUN_MAX   = '1;
    localparam logic [DOT_W-1:0] DOT_RESET = 16'd100;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DUP     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEAD,
        S_MARK,
        S_SPACE
    } state_t;

    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] code;
        logic [ECNT_W-1:0] count;
        logic [PAT_W-1:0]  pattern;
    } tbl_write_t;

    typedef struct packed {
        logic              hit;
        logic [ECNT_W-1:0] count;
        logic [PAT_W-1:0]  pattern;
    } tbl_entry_t;

endpackage

[sv/mck_table.sv]
module mck_table
    import mck_pkg::*;
#(
    parameter int MAX_SYMBOLS   = 8,
    parameter int CHAR_SET_SIZE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [CODE_W-1:0] rd_code,
    input  tbl_write_t        wr,
    output tbl_entry_t        entry
);

    localparam int IW = (CHAR_SET_SIZE > 2) ? $clog2(CHAR_SET_SIZE) : 1;
    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    logic [CW+PAT_W-1:0]      mem [CHAR_SET_SIZE];
    logic [CHAR_SET_SIZE-1:0] valid_reg;
    logic [CW+PAT_W-1:0]      rd_data_reg;
    logic                     rd_hit_reg;
    logic [IW-1:0]            rd_idx;
    logic [IW-1:0]            wr_idx;

    assign rd_idx = rd_code[IW-1:0];
    assign wr_idx = wr.code[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_idx] <= {wr.count[CW-1:0], wr.pattern};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
            rd_hit_reg  <= valid_reg[rd_idx];
        end
    end

    assign entry.hit     = rd_hit_reg;
    assign entry.count   = ECNT_W'(rd_data_reg[CW+PAT_W-1:PAT_W]);
    assign entry.pattern = rd_data_reg[PAT_W-1:0];

endmodule

[sv/mck_run_unit.sv]
module mck_run_unit
    import mck_pkg::*;
(
    input  logic [FACTOR_W-1:0] factor,
    input  logic [DOT_W-1:0]    dot_time,
    output logic [RUN_W-1:0]    run
);

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(factor) * PROD_W'(dot_time);
    assign run     = (product > PROD_W'(RUN_MAX)) ? RUN_MAX : product[RUN_W-1:0];

endmodule

[sv/mck_seq.sv]
module mck_seq
    import mck_pkg::*;
#(
    parameter int DASH_FACTOR   = 3,
    parameter int GAP_FACTOR    = 3,
    parameter int MAX_SYMBOLS   = 8,
    parameter int CHAR_SET_SIZE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  logic [CODE_W-1:0]   char_code,
    input  logic [CNT_W-1:0]    symbol_count,
    input  logic [PAT_W-1:0]    symbol_bits,
    input  logic                lead_gap,
    input  tbl_entry_t          entry,
    input  logic [RUN_W-1:0]    run,
    output logic                busy,
    output logic                rd_en,
    output logic [CODE_W-1:0]   rd_code,
    output tbl_write_t          wr,
    output logic [FACTOR_W-1:0] factor,
    output logic                result_strobe,
    output logic                level,
    output logic [RUN_W-1:0]    run_length,
    output logic [1:0]          status,
    output logic                last
);

    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    state_t state_reg, state_next;

    logic              action_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CNT_W-1:0]  count_in_reg;
    logic [PAT_W-1:0]  bits_reg;
    logic              lead_reg;

    logic [CW-1:0]     sym_count_reg, sym_count_next;
    logic [PAT_W-1:0]  pattern_reg, pattern_next;
    logic [CW-1:0]     sym_idx_reg, sym_idx_next;

    logic              strobe_reg, strobe_next;
    logic              level_reg, level_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              in_range;
    logic              is_final;
    logic              is_dash;
    logic [ECNT_W-1:0] load_count;
    logic [PAT_W-1:0]  shifted;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign rd_en    = accept;
    assign rd_code  = char_code;
    assign in_range = ({1'b0, code_reg} < (CODE_W + 1)'(CHAR_SET_SIZE));
    assign is_final = (({1'b0, sym_idx_reg} + (CW + 1)'(1)) == {1'b0, sym_count_reg});
    assign shifted  = pattern_reg >> sym_idx_reg;
    assign is_dash  = shifted[0];

    always_comb
    begin
        load_count = ECNT_W'(count_in_reg);
        if (load_count == '0)
        begin
            load_count = ECNT_W'(1);
        end
        if (load_count > ECNT_W'(MAX_SYMBOLS))
        begin
            load_count = ECNT_W'(MAX_SYMBOLS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= action;
            code_reg     <= char_code;
            count_in_reg <= symbol_count;
            bits_reg     <= symbol_bits;
            lead_reg     <= lead_gap;
        end
        sym_count_reg <= sym_count_next;
        pattern_reg   <= pattern_next;
        sym_idx_reg   <= sym_idx_next;
        level_reg     <= level_next;
        run_reg       <= run_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (action_reg && in_range && entry.hit)
                begin
                    state_next = lead_reg ? S_LEAD : S_MARK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LEAD:
            begin
                state_next = S_MARK;
            end
            S_MARK:
            begin
                state_next = S_SPACE;
            end
            S_SPACE:
            begin
                state_next = is_final ? S_IDLE : S_MARK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sym_count_next = sym_count_reg;
        pattern_next   = pattern_reg;
        sym_idx_next   = sym_idx_reg;
        wr             = '0;
        factor         = FACTOR_W'(1);
        strobe_next    = 1'b0;
        level_next     = 1'b0;
        run_next       = run;
        status_next    = ST_OK;
        last_next      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_CHECK:
            begin
                run_next = '0;
                if (!in_range)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_UNKNOWN;
                    last_next   = 1'b1;
                end
                else if (!action_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    if (entry.hit)
                    begin
                        status_next = ST_DUP;
                    end
                    else
                    begin
                        wr.en      = 1'b1;
                        wr.code    = code_reg;
                        wr.count   = load_count;
                        wr.pattern = bits_reg;
                    end
                end
                else if (!entry.hit)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_UNKNOWN;
                    last_next   = 1'b1;
                end
                else
                begin
                    sym_count_next = entry.count[CW-1:0];
                    pattern_next   = entry.pattern;
                    sym_idx_next   = '0;
                end
            end
            S_LEAD:
            begin
                factor      = FACTOR_W'(GAP_FACTOR);
                strobe_next = 1'b1;
            end
            S_MARK:
            begin
                factor      = is_dash ? FACTOR_W'(DASH_FACTOR) : FACTOR_W'(1);
                strobe_next = 1'b1;
                level_next  = 1'b1;
            end
            S_SPACE:
            begin
                factor       = is_final ? FACTOR_W'(GAP_FACTOR) : FACTOR_W'(1);
                strobe_next  = 1'b1;
                last_next    = is_final;
                sym_idx_next = sym_idx_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign result_strobe = strobe_reg;
    assign level         = level_reg;
    assign run_length    = run_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

[sv/morse_character_keyer.sv]
// Channel    Handshake                  Payload
// command    start, busy                action, char_code, symbol_count, symbol_bits, lead_gap
// result     result_strobe              level, run_length, status, last
// config     dot_time_we                dot_time_wdata
//
// A command is taken when start is high and busy is low. A load or a rejected send keeps
// the block busy in its check state only; a send of N symbols passes check, a lead state
// with a leading gap, then a mark and a space per symbol, each issuing one run per cycle
// through the shared run multiplier. Each result beat appears in the cycle after its step.
// Reset clears the table's valid marks and sets dot_time to 100.
// The receiver cannot stall: every result beat lasts exactly one cycle.
module morse_character_keyer
    import mck_pkg::*;
#(
    parameter int DASH_FACTOR   = 3,
    parameter int GAP_FACTOR    = 3,
    parameter int MAX_SYMBOLS   = 8,
    parameter int CHAR_SET_SIZE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [CODE_W-1:0] char_code,
    input  logic [CNT_W-1:0]  symbol_count,
    input  logic [PAT_W-1:0]  symbol_bits,
    input  logic              lead_gap,
    input  logic              dot_time_we,
    input  logic [DOT_W-1:0]  dot_time_wdata,
    output logic              result_strobe,
    output logic              level,
    output logic [RUN_W-1:0]  run_length,
    output logic [1:0]        status,
    output logic              last
);

    logic [DOT_W-1:0]    dot_time_reg, dot_time_next;
    logic                rd_en;
    logic [CODE_W-1:0]   rd_code;
    tbl_write_t          wr;
    tbl_entry_t          entry;
    logic [FACTOR_W-1:0] factor;
    logic [RUN_W-1:0]    run;

    always_comb
    begin
        dot_time_next = dot_time_reg;
        if (dot_time_we && (dot_time_wdata != '0))
        begin
            dot_time_next = dot_time_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_time_reg <= DOT_RESET;
        end
        else
        begin
            dot_time_reg <= dot_time_next;
        end
    end

    mck_table #(
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .CHAR_SET_SIZE (CHAR_SET_SIZE)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_code (rd_code),
        .wr      (wr),
        .entry   (entry)
    );

    mck_run_unit u_run_unit (
        .factor   (factor),
        .dot_time (dot_time_reg),
        .run      (run)
    );

    mck_seq #(
        .DASH_FACTOR   (DASH_FACTOR),
        .GAP_FACTOR    (GAP_FACTOR),
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .CHAR_SET_SIZE (CHAR_SET_SIZE)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .char_code     (char_code),
        .symbol_count  (symbol_count),
        .symbol_bits   (symbol_bits),
        .lead_gap      (lead_gap),
        .entry         (entry),
        .run           (run),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_code       (rd_code),
        .wr            (wr),
        .factor        (factor),
        .result_strobe (result_strobe),
        .level         (level),
        .run_length    (run_length),
        .status        (status),
        .last          (last)
    );

endmodule
